// ===== hw/rtl/bsfr_pkg.sv =====
// Shared types and constants for the byte-stuffing frame receiver.
package bsfr_pkg;

	localparam int unsigned LEN_W     = 13;
	localparam int unsigned TICK_W    = 16;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_W     = 16;

	localparam logic [LEN_W-1:0]  MAX_FRAME       = LEN_W'(4096);
	localparam logic [LEN_W-1:0]  MAX_LENGTH_RST  = LEN_W'(4096);
	localparam logic [TICK_W-1:0] TIMEOUT_RST     = TICK_W'(5000);

	localparam logic [7:0] BYTE_BEGIN = 8'hFE;
	localparam logic [7:0] BYTE_END   = 8'hFC;
	localparam logic [7:0] BYTE_ESC   = 8'hFD;
	localparam logic [7:0] ESC_XOR    = 8'h20;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 1'b1;

	typedef enum logic [1:0] {
		PH_HUNT  = 2'd0,
		PH_FRAME = 2'd1,
		PH_ESC   = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_END  = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE    = 2'd0,
		ERR_BIG     = 2'd1,
		ERR_ESC     = 2'd2,
		ERR_TIMEOUT = 2'd3
	} err_t;

endpackage

// ===== hw/rtl/byte_stuffing_frame_receiver.sv =====
// Byte-stuffing frame receiver: deframes an escaped byte stream with tick timeouts.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-------------------------------------------
//  in       | sink      | in_valid / in_stall | mode, rx_byte
//  out      | source    | out_valid/out_stall | kind, data_byte, frame_length, error_code, last
//  cfg      | sink      | cfg_we              | cfg_index, cfg_data
//
// One beat per cycle in each direction while out is not stalled. A beat is captured in the
// input register, decided against the frame state while it sits there and lands in the result
// register. Ticks short of the timeout, dropped hunting bytes and escape bytes leave no result
// beat. arst_n clears the handshake valids, the phase, the counters and the configuration to
// its defaults. A stall on out holds a full result register and, once the input register is
// full, raises in_stall in the same cycle.
module byte_stuffing_frame_receiver
	import bsfr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// input channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 mode,
	input  logic [7:0]           rx_byte,
	// result channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           kind,
	output logic [7:0]           data_byte,
	output logic [LEN_W-1:0]     frame_length,
	output logic [1:0]           error_code,
	output logic                 last,
	// configuration
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	// configuration registers
	logic [LEN_W-1:0]  max_length_q;
	logic [TICK_W-1:0] timeout_q;

	// frame state
	phase_t            phase_q, phase_d;
	logic [LEN_W-1:0]  count_q, count_d;
	logic [TICK_W-1:0] idle_q, idle_d;

	// input register
	logic              valid_s1;
	logic              mode_s1;
	logic [7:0]        byte_s1;

	// result register
	logic              valid_s2;
	kind_t             kind_s2;
	logic [7:0]        data_s2;
	logic [LEN_W-1:0]  len_s2;
	err_t              err_s2;
	logic              last_s2;

	// decision
	logic              out_free;
	logic              proc;
	logic              tick;
	logic              timeout_hit;
	logic              is_ctrl;
	logic              is_payload;
	logic              too_big;
	logic [LEN_W-1:0]  limit;
	logic [LEN_W-1:0]  count_inc;
	logic [7:0]        pay_byte;

	logic              res_valid;
	kind_t             res_kind;
	logic [7:0]        res_data;
	logic [LEN_W-1:0]  res_len;
	err_t              res_err;
	logic              res_last;

	// Handshake: the result slot frees when empty or being taken this cycle.
	assign out_free = !valid_s2 || !out_stall;
	assign proc     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	// Per-beat decode.
	assign tick        = mode_s1;
	assign timeout_hit = idle_q >= timeout_q;
	assign is_ctrl     = (byte_s1 == BYTE_BEGIN) || (byte_s1 == BYTE_END) ||
	                     (byte_s1 == BYTE_ESC);
	assign limit       = (max_length_q > MAX_FRAME) ? MAX_FRAME : max_length_q;
	assign too_big     = count_q >= limit;
	assign count_inc   = count_q + LEN_W'(1);
	assign pay_byte    = (phase_q == PH_ESC) ? (byte_s1 ^ ESC_XOR) : byte_s1;
	// a byte that goes into the frame as payload (plain or unescaped)
	assign is_payload  = !tick &&
	                     (((phase_q == PH_FRAME) && (byte_s1 != BYTE_END) &&
	                       (byte_s1 != BYTE_ESC)) ||
	                      ((phase_q == PH_ESC) && !is_ctrl));

	// Next state of the deframer.
	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		idle_d  = idle_q;
		if (tick) begin
			if (timeout_hit) begin
				// timeout aborts whatever phase we are in
				phase_d = PH_HUNT;
				count_d = '0;
				idle_d  = '0;
			end else begin
				idle_d = idle_q + TICK_W'(1);
			end
		end else begin
			idle_d = '0;
			if (is_payload) begin
				if (too_big) begin
					phase_d = PH_HUNT;
					count_d = '0;
				end else begin
					phase_d = PH_FRAME;
					count_d = count_inc;
				end
			end else begin
				case (phase_q)
					PH_FRAME: begin
						if (byte_s1 == BYTE_END) begin
							phase_d = PH_HUNT;
							count_d = '0;
						end else begin
							// only the escape byte is left here
							phase_d = PH_ESC;
						end
					end
					PH_ESC: begin
						// escaped control byte: abort
						phase_d = PH_HUNT;
						count_d = '0;
					end
					default: begin
						// hunting, or an unused code: look for the begin byte
						if (byte_s1 == BYTE_BEGIN) begin
							phase_d = PH_FRAME;
							count_d = '0;
						end else begin
							phase_d = PH_HUNT;
						end
					end
				endcase
			end
		end
	end

	// Result beat for the current item.
	always_comb begin
		res_valid = 1'b0;
		res_kind  = KIND_DATA;
		res_data  = '0;
		res_len   = count_q;
		res_err   = ERR_NONE;
		res_last  = 1'b0;
		if (tick) begin
			if (timeout_hit) begin
				res_valid = 1'b1;
				res_kind  = KIND_ERR;
				res_err   = ERR_TIMEOUT;
				res_last  = 1'b1;
			end
		end else if (is_payload) begin
			res_valid = 1'b1;
			if (too_big) begin
				res_kind = KIND_ERR;
				res_err  = ERR_BIG;
				res_last = 1'b1;
			end else begin
				res_data = pay_byte;
				res_len  = count_inc;
			end
		end else begin
			case (phase_q)
				PH_FRAME: begin
					if (byte_s1 == BYTE_END) begin
						res_valid = 1'b1;
						res_kind  = KIND_END;
						res_last  = 1'b1;
					end
				end
				PH_ESC: begin
					res_valid = 1'b1;
					res_kind  = KIND_ERR;
					res_err   = ERR_ESC;
					res_last  = 1'b1;
				end
				default: begin
					res_valid = 1'b0;
				end
			endcase
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= MAX_LENGTH_RST;
			timeout_q    <= TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_LENGTH: max_length_q <= cfg_data[LEN_W-1:0];
				CFG_TIMEOUT:    timeout_q    <= cfg_data[TICK_W-1:0];
				default:        max_length_q <= max_length_q;
			endcase
		end
	end

	// Frame state: advance once per decided beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			count_q <= '0;
			idle_q  <= '0;
		end else if (proc) begin
			phase_q <= phase_d;
			count_q <= count_d;
			idle_q  <= idle_d;
		end
	end

	// Input register: capture a beat whenever it is not held.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mode_s1 <= mode;
			byte_s1 <= rx_byte;
		end
	end

	// Result register: load on a result, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= proc && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && res_valid) begin
			kind_s2 <= res_kind;
			data_s2 <= res_data;
			len_s2  <= res_len;
			err_s2  <= res_err;
			last_s2 <= res_last;
		end
	end

	assign out_valid    = valid_s2;
	assign kind         = kind_s2;
	assign data_byte    = data_s2;
	assign frame_length = len_s2;
	assign error_code   = err_s2;
	assign last         = last_s2;

	// Checks on the deframer's own logic.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_FRAME)
		else $error("frame byte count above the frame ceiling");

	a_hunt_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HUNT) |-> (count_q == '0))
		else $error("byte count not cleared while hunting");

	a_last_hunts: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && res_valid && res_last) |=> (phase_q == PH_HUNT))
		else $error("closing result did not return to hunting");

	a_data_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (kind_s2 == KIND_DATA)) |-> (!last_s2 && (err_s2 == ERR_NONE)))
		else $error("payload beat flagged as last or error");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2))
		else $error("input held with a free pipeline");

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the byte-stuffing frame receiver: random frames against a deframer model.
module testbench;
	import bsfr_pkg::*;

	// Mode codes of an input beat.
	localparam logic MODE_BYTE = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	// Give up after this many cycles with no beat on either channel.
	localparam int unsigned QUIET_LIMIT = 4000;
	// Minimum input beats per random segment.
	localparam int unsigned SEGMENT_BEATS = 205;

	typedef struct {
		kind_t            kind;
		logic [7:0]       data;
		logic [LEN_W-1:0] length;
		err_t             code;
		logic             ends;
	} frame_result_t;

	// Deframer model plus the queue of results it still expects from the block.
	class deframer_model;
		logic [LEN_W-1:0]  max_length;
		logic [TICK_W-1:0] timeout_ticks;
		phase_t            phase;
		logic [LEN_W-1:0]  byte_count;
		logic [TICK_W-1:0] idle_ticks;
		frame_result_t     expected_q[$];
		int unsigned       mismatches;

		function new();
			max_length    = MAX_LENGTH_RST;
			timeout_ticks = TIMEOUT_RST;
			phase         = PH_HUNT;
			byte_count    = '0;
			idle_ticks    = '0;
			mismatches    = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
			if (idx == CFG_MAX_LENGTH) begin
				max_length = value[LEN_W-1:0];
			end else begin
				timeout_ticks = value[TICK_W-1:0];
			end
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		function void push(kind_t k, logic [7:0] d, err_t c, logic e);
			frame_result_t r;
			r.kind   = k;
			r.data   = d;
			r.length = byte_count;
			r.code   = c;
			r.ends   = e;
			expected_q.push_back(r);
		endfunction

		function void flag_error(err_t c);
			push(KIND_ERR, 8'h00, c, 1'b1);
			phase      = PH_HUNT;
			byte_count = '0;
		endfunction

		function void take_payload(logic [7:0] b);
			logic [LEN_W-1:0] limit;
			limit = (max_length > MAX_FRAME) ? MAX_FRAME : max_length;
			phase = PH_FRAME;
			if (byte_count >= limit) begin
				flag_error(ERR_BIG);
			end else begin
				byte_count = byte_count + 1'b1;
				push(KIND_DATA, b, ERR_NONE, 1'b0);
			end
		endfunction

		// Advance the model by one accepted input beat.
		function void note_beat(logic m, logic [7:0] b);
			if (m == MODE_TICK) begin
				if (idle_ticks >= timeout_ticks) begin
					idle_ticks = '0;
					flag_error(ERR_TIMEOUT);
				end else begin
					idle_ticks = idle_ticks + 1'b1;
				end
			end else begin
				idle_ticks = '0;
				case (phase)
					PH_FRAME: begin
						if (b == BYTE_END) begin
							push(KIND_END, 8'h00, ERR_NONE, 1'b1);
							phase      = PH_HUNT;
							byte_count = '0;
						end else if (b == BYTE_ESC) begin
							phase = PH_ESC;
						end else begin
							take_payload(b);
						end
					end
					PH_ESC: begin
						if (b == BYTE_BEGIN || b == BYTE_END || b == BYTE_ESC) begin
							flag_error(ERR_ESC);
						end else begin
							take_payload(b ^ ESC_XOR);
						end
					end
					default: begin
						// hunting, or an unused phase value: wait for the begin byte
						phase = PH_HUNT;
						if (b == BYTE_BEGIN) begin
							phase      = PH_FRAME;
							byte_count = '0;
						end
					end
				endcase
			end
		endfunction

		task report(string msg);
			$display("%0t: %s", $time, msg);
			mismatches++;
		endtask

		// Compare one result beat with the oldest expectation.
		task check_result(logic [1:0] k, logic [7:0] d, logic [LEN_W-1:0] len,
				logic [1:0] c, logic e);
			frame_result_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected result beat: kind %0d length %0d", k, len));
			end else begin
				want = expected_q.pop_front();
				if (k !== want.kind)
					report($sformatf("kind: got %0d, want %0d", k, want.kind));
				if (d !== want.data)
					report($sformatf("data_byte: got %h, want %h", d, want.data));
				if (len !== want.length)
					report($sformatf("frame_length: got %0d, want %0d", len, want.length));
				if (c !== want.code)
					report($sformatf("error_code: got %0d, want %0d", c, want.code));
				if (e !== want.ends)
					report($sformatf("last: got %0d, want %0d", e, want.ends));
			end
		endtask
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic             mode = MODE_BYTE;
	logic [7:0]       rx_byte = 8'h00;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [1:0]       kind;
	logic [7:0]       data_byte;
	logic [LEN_W-1:0] frame_length;
	logic [1:0]       error_code;
	logic             res_last;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_MAX_LENGTH;
	logic [CFG_W-1:0]     cfg_data = '0;

	deframer_model sb = new();

	int unsigned send_idle_pct = 0;   // chance per cycle that the sender holds off
	int unsigned stall_pct = 0;       // chance per cycle that the receiver stalls
	int unsigned beat_count = 0;      // input beats accepted so far
	int unsigned quiet_cycles = 0;

	byte_stuffing_frame_receiver dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.data_byte    (data_byte),
		.frame_length (frame_length),
		.error_code   (error_code),
		.last         (res_last),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Receiver side: stall at random with the current percentage.
	always @(posedge clk) begin
		out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
	end

	// Sample both channels at the edge, before anything driven at this edge lands.
	// Feed accepted input beats to the model, check accepted result beats, and
	// end the run if neither channel moves for too long.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			sb.note_beat(mode, rx_byte);
			beat_count++;
		end
		if (arst_n && out_valid && !out_stall) begin
			sb.check_result(kind, data_byte, frame_length, error_code, res_last);
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: watchdog: no beat for %0d cycles", $time, QUIET_LIMIT);
			$display("Mismatches found");
			$finish;
		end
	end

	// Drive one input beat and hold it until the block takes it. Idle gaps come
	// first, so valid never drops between two beats without a full cycle low.
	task send_beat(logic m, logic [7:0] b);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode     <= m;
		rx_byte  <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Hold off the sender until every expected result has come, then let the
	// block finish any beat that leaves no result.
	task drain(int unsigned extra);
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (extra) @(posedge clk);
	endtask

	// Write both registers back to back; call only with the block idle.
	task write_config(logic [CFG_W-1:0] max_val, logic [CFG_W-1:0] tmo_val);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_MAX_LENGTH;
		cfg_data  <= max_val;
		@(posedge clk);
		sb.write_reg(CFG_MAX_LENGTH, max_val);
		cfg_index <= CFG_TIMEOUT;
		cfg_data  <= tmo_val;
		@(posedge clk);
		sb.write_reg(CFG_TIMEOUT, tmo_val);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// One random chunk of link traffic: mostly well-formed frames with random
	// content, some noise, tick bursts and broken escapes.
	task send_frame(bit hold);
		int unsigned pick;
		int unsigned n;
		logic [7:0]  b;
		if (hold || $urandom_range(29) == 0) drain(0);
		pick = $urandom_range(99);
		if (pick < 12) begin
			// noise: bytes and ticks in any order
			repeat ($urandom_range(1, 4))
				send_beat(($urandom_range(2) == 0) ? MODE_TICK : MODE_BYTE, 8'($urandom));
		end else if (pick < 18) begin
			// tick burst, long enough to trip short timeouts
			repeat ($urandom_range(1, 6)) send_beat(MODE_TICK, 8'($urandom));
		end else begin
			send_beat(MODE_BYTE, BYTE_BEGIN);
			n = ($urandom_range(7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
			repeat (n) begin
				b = 8'($urandom);
				if ($urandom_range(15) == 0) send_beat(MODE_TICK, 8'($urandom));
				if (b == BYTE_BEGIN || b == BYTE_END || b == BYTE_ESC) begin
					// stuff control bytes, but now and then let one through raw
					if ($urandom_range(9) == 0) begin
						send_beat(MODE_BYTE, b);
					end else begin
						send_beat(MODE_BYTE, BYTE_ESC);
						send_beat(MODE_BYTE, b ^ ESC_XOR);
					end
				end else if ($urandom_range(39) == 0) begin
					// broken escape: a control byte right after the escape
					send_beat(MODE_BYTE, BYTE_ESC);
					case ($urandom_range(2))
						0: send_beat(MODE_BYTE, BYTE_BEGIN);
						1: send_beat(MODE_BYTE, BYTE_END);
						default: send_beat(MODE_BYTE, BYTE_ESC);
					endcase
				end else if ($urandom_range(7) == 0) begin
					// escape an ordinary byte; the block undoes the XOR
					send_beat(MODE_BYTE, BYTE_ESC);
					send_beat(MODE_BYTE, b ^ ESC_XOR);
				end else begin
					send_beat(MODE_BYTE, b);
				end
			end
			// leave some frames open so the next begin byte lands inside a frame
			if ($urandom_range(7) != 0) send_beat(MODE_BYTE, BYTE_END);
		end
	endtask

	initial begin
		int unsigned      seg_end;
		int unsigned      frame_no;
		logic [CFG_W-1:0] max_val;
		logic [CFG_W-1:0] tmo_val;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed traffic with the reset configuration.
		send_beat(MODE_BYTE, BYTE_END);          // dropped while hunting
		send_beat(MODE_TICK, 8'hFF);             // tick ignores its byte
		send_beat(MODE_BYTE, BYTE_BEGIN);
		send_beat(MODE_BYTE, 8'h00);
		send_beat(MODE_BYTE, 8'hFF);
		send_beat(MODE_BYTE, BYTE_BEGIN);        // begin byte inside a frame is payload
		send_beat(MODE_BYTE, BYTE_ESC);
		send_beat(MODE_BYTE, 8'hDE);             // escaped begin byte
		send_beat(MODE_BYTE, BYTE_END);
		send_beat(MODE_BYTE, BYTE_BEGIN);        // invalid escape of the end byte
		send_beat(MODE_BYTE, BYTE_ESC);
		send_beat(MODE_BYTE, BYTE_END);
		send_beat(MODE_BYTE, BYTE_BEGIN);        // invalid escape of the escape byte
		send_beat(MODE_BYTE, 8'h01);
		send_beat(MODE_BYTE, BYTE_ESC);
		send_beat(MODE_BYTE, BYTE_ESC);
		send_beat(MODE_BYTE, BYTE_BEGIN);        // invalid escape of the begin byte
		send_beat(MODE_BYTE, BYTE_ESC);
		send_beat(MODE_BYTE, BYTE_BEGIN);
		send_beat(MODE_BYTE, BYTE_BEGIN);        // empty frame
		send_beat(MODE_BYTE, BYTE_END);

		// Zero limit and zero timeout: every tick and every payload byte fails.
		drain(4);
		write_config('0, '0);
		send_beat(MODE_TICK, 8'h00);
		send_beat(MODE_BYTE, BYTE_BEGIN);
		send_beat(MODE_BYTE, 8'h41);

		// Random segments: cycle through the idling mixes and register settings.
		for (int seg = 0; seg < 8; seg++) begin
			drain(4);
			case (seg % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 72; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 72; end
				default: begin send_idle_pct = 26; stall_pct = 26; end
			endcase
			case (seg)
				0: begin max_val = 16'hFFFF; tmo_val = 16'hFFFF; end  // limit clamps to MAX_FRAME
				1: begin max_val = 16'd1;    tmo_val = 16'd0;    end
				2: begin max_val = 16'd4096; tmo_val = 16'd1;    end
				3: begin max_val = 16'd0;    tmo_val = 16'd3;    end
				4: begin max_val = 16'd5;    tmo_val = 16'd2;    end
				5: begin max_val = 16'd12;   tmo_val = 16'd5000; end
				6: begin max_val = 16'd3;    tmo_val = 16'd4;    end
				default: begin max_val = 16'hE007; tmo_val = 16'h8000; end  // upper bits dropped
			endcase
			write_config(max_val, tmo_val);
			seg_end  = beat_count + SEGMENT_BEATS;
			frame_no = 0;
			while (beat_count < seg_end) begin
				send_frame(frame_no == 5);
				frame_no++;
			end
		end

		// Wait out every expected result, then watch for strays.
		drain(8);
		if (sb.mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
